// ----- hdl/ps2md_pkg.sv -----
`default_nettype none

package ps2md_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int SIZE_BITS = 12;
  localparam int OUT_COORD_BITS = 12;

  localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 12'd640;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 12'd480;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd2;

  // button bits in the header byte
  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;

  typedef enum logic [1:0] {
    PH_HDR = 2'd0,
    PH_DX  = 2'd1,
    PH_DY  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    PRESS_NONE   = 2'd0,
    PRESS_LEFT   = 2'd1,
    PRESS_RIGHT  = 2'd2,
    PRESS_MIDDLE = 2'd3
  } press_t;

  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

  typedef struct packed {
    logic                 wr_width;
    logic                 wr_height;
    logic [SIZE_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic                      moved;
    logic [OUT_COORD_BITS-1:0] x;
    logic [OUT_COORD_BITS-1:0] y;
    logic                      clicked;
    press_t                    press;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/ps2_mouse_packet_decoder_unit.sv -----
`default_nettype none

// PS/2 mouse packet decoder. Takes one controller byte per cycle on the in_
// stream (tuser flags bytes from the aux device) and assembles three-byte
// packets, header then X delta then Y delta, with no sync check. Each packet
// yields one result via the packet register and then the output register:
// the cursor position after adding X and the negated Y delta, clamped to
// 0..size-1 per axis, plus move and click flags and, on a new press, the
// highest-priority held button (middle, right, left). Bytes are dropped while
// enable is clear or the aux flag is low. Writing a screen size recenters that
// axis. Takes one byte per cycle; an out_ stall backs up through both registers.
module ps2_mouse_packet_decoder_unit #(
  parameter int COORD_BITS = ps2md_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]                          in_tuser,   // [0] from_aux
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [11:0] cursor_x_out, [23:12] cursor_y_out
  output logic [2*ps2md_pkg::OUT_COORD_BITS-1:0]   out_tdata,
  output logic [3:0]                               out_tuser,  // [0] moved, [1] clicked,
                                                               // [3:2] press_code
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ps2md_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ps2md_pkg::SIZE_BITS-1:0]     cfg_data
);
  import ps2md_pkg::*;

  logic    enable_r;
  logic    cfg_we;
  cfg_wr_t cfg_wr;
  logic    pkt_valid, pkt_ready;
  pkt_t    pkt;
  result_t result;

  assign cfg_ready        = 1'b1;
  assign cfg_we           = cfg_valid && cfg_ready;
  assign cfg_wr.wr_width  = cfg_we && (cfg_index == CFG_WIDTH);
  assign cfg_wr.wr_height = cfg_we && (cfg_index == CFG_HEIGHT);
  assign cfg_wr.data      = cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_we && cfg_index == CFG_ENABLE) begin
      enable_r <= cfg_data[0];
    end
  end

  ps2md_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_aux    (in_tuser[0]),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_ready (pkt_ready)
  );

  ps2md_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_ready (pkt_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = {result.y, result.x};
  assign out_tuser = {result.press, result.clicked, result.moved};

endmodule

`default_nettype wire

// ----- hdl/ps2md_packer.sv -----
`default_nettype none

module ps2md_packer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           enable,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_aux,
  output logic                pkt_valid,
  output ps2md_pkg::pkt_t     pkt,
  input  wire logic           pkt_ready
);
  import ps2md_pkg::*;

  phase_t     state_r, state_nxt;
  logic [2:0] hdr_r;
  logic [7:0] dx_r;
  logic       pkt_valid_r;
  pkt_t       pkt_r;
  logic       take;
  logic       cap_hdr, cap_dx, fire;

  assign in_tready = !pkt_valid_r || pkt_ready;
  // bytes not from the mouse, or while disabled, are dropped without effect
  assign take = in_tvalid && in_tready && enable && in_aux;

  always_comb begin
    state_nxt = state_r;
    if (take) begin
      unique case (state_r)
        PH_HDR:  state_nxt = PH_DX;
        PH_DX:   state_nxt = PH_DY;
        PH_DY:   state_nxt = PH_HDR;
        default: state_nxt = PH_DX;
      endcase
    end
  end

  always_comb begin
    cap_hdr = 1'b0;
    cap_dx  = 1'b0;
    fire    = 1'b0;
    unique case (state_r)
      PH_DX:   cap_dx  = take;
      PH_DY:   fire    = take;
      default: cap_hdr = take;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_HDR;
      pkt_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_tready) begin
        pkt_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_hdr) begin
      hdr_r <= in_byte[2:0];
    end
    if (cap_dx) begin
      dx_r <= in_byte;
    end
    if (fire) begin
      pkt_r.buttons <= hdr_r;
      pkt_r.dx      <= dx_r;
      pkt_r.dy      <= in_byte;
    end
  end

  assign pkt_valid = pkt_valid_r;
  assign pkt       = pkt_r;

`ifndef SYNTHESIS
  a_third_byte_emits: assert property (@(posedge clk) disable iff (!rst_n)
    take && state_r == PH_DY |=> pkt_valid_r)
    else $error("third byte did not produce a packet");

  a_packet_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pkt_valid_r) |-> state_r == PH_HDR)
    else $error("packet emitted without returning to header phase");

  a_ignored_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> state_r == $past(state_r))
    else $error("phase moved on an ignored byte");
`endif

endmodule

`default_nettype wire

// ----- hdl/ps2md_cursor.sv -----
`default_nettype none

module ps2md_cursor #(
  parameter int COORD_BITS = ps2md_pkg::COORD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ps2md_pkg::cfg_wr_t cfg_wr,
  input  wire logic              pkt_valid,
  input  wire ps2md_pkg::pkt_t   pkt,
  output logic                   pkt_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ps2md_pkg::result_t     result
);
  import ps2md_pkg::*;

  localparam int MASK = (1 << COORD_BITS) - 1;
  localparam int VW   = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

  // clamp bound: size-1, limited to the coordinate range; zero size pins to 0
  function automatic logic [COORD_BITS-1:0] bound_of(input logic [SIZE_BITS-1:0] size);
    logic [VW-1:0] m1;
    m1 = VW'(size) - VW'(1);
    if (size == '0) begin
      return '0;
    end else if (m1 > VW'(MASK)) begin
      return COORD_BITS'(MASK);
    end
    return COORD_BITS'(m1);
  endfunction

  function automatic logic [COORD_BITS-1:0] center_of(input logic [SIZE_BITS-1:0] size);
    return COORD_BITS'(size >> 1);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic [COORD_BITS-1:0] pos,
    input logic signed [9:0]     delta,
    input logic [COORD_BITS-1:0] bound
  );
    logic signed [VW-1:0] v;
    v = $signed(VW'(pos)) + VW'(delta);
    if (v < 0) begin
      return '0;
    end else if (v > $signed(VW'(bound))) begin
      return bound;
    end
    return COORD_BITS'(v);
  endfunction

  logic [COORD_BITS-1:0] cursor_x_r, cursor_y_r;
  logic [COORD_BITS-1:0] bound_x_r, bound_y_r;
  logic [2:0]            prev_btn_r;
  logic                  out_valid_r;
  result_t               result_r;

  logic                  take;
  logic                  moved;
  logic signed [9:0]     dx_s, dy_neg;
  logic [COORD_BITS-1:0] x_nxt, y_nxt;
  logic [2:0]            rising;
  press_t                press;

  assign pkt_ready = !out_valid_r || out_ready;
  assign take      = pkt_valid && pkt_ready;

  assign moved  = (pkt.dx != 8'd0) || (pkt.dy != 8'd0);
  assign dx_s   = 10'($signed(pkt.dx));
  assign dy_neg = -10'($signed(pkt.dy));

  always_comb begin
    x_nxt = cursor_x_r;
    y_nxt = cursor_y_r;
    if (moved) begin
      x_nxt = clamp_axis(cursor_x_r, dx_s, bound_x_r);
      y_nxt = clamp_axis(cursor_y_r, dy_neg, bound_y_r);
    end
  end

  assign rising = pkt.buttons & ~prev_btn_r;

  always_comb begin
    press = PRESS_NONE;
    if (rising != 3'b000) begin
      priority if (pkt.buttons[BTN_MIDDLE]) begin
        press = PRESS_MIDDLE;
      end else if (pkt.buttons[BTN_RIGHT]) begin
        press = PRESS_RIGHT;
      end else if (pkt.buttons[BTN_LEFT]) begin
        press = PRESS_LEFT;
      end else begin
        press = PRESS_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= center_of(WIDTH_RST);
      cursor_y_r  <= center_of(HEIGHT_RST);
      bound_x_r   <= bound_of(WIDTH_RST);
      bound_y_r   <= bound_of(HEIGHT_RST);
      prev_btn_r  <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      if (pkt_ready) begin
        out_valid_r <= pkt_valid;
      end
      if (take) begin
        prev_btn_r <= pkt.buttons;
      end
      // size writes recenter the axis
      if (cfg_wr.wr_width) begin
        bound_x_r  <= bound_of(cfg_wr.data);
        cursor_x_r <= center_of(cfg_wr.data);
      end else if (take) begin
        cursor_x_r <= x_nxt;
      end
      if (cfg_wr.wr_height) begin
        bound_y_r  <= bound_of(cfg_wr.data);
        cursor_y_r <= center_of(cfg_wr.data);
      end else if (take) begin
        cursor_y_r <= y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r.moved   <= moved;
      result_r.x       <= OUT_COORD_BITS'(x_nxt);
      result_r.y       <= OUT_COORD_BITS'(y_nxt);
      result_r.clicked <= (rising != 3'b000);
      result_r.press   <= press;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

`ifndef SYNTHESIS
  a_x_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_x_r <= bound_x_r)
    else $error("cursor x beyond clamp bound");

  a_y_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_y_r <= bound_y_r)
    else $error("cursor y beyond clamp bound");

  a_click_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.clicked |-> result_r.press != PRESS_NONE)
    else $error("click reported without a button code");

  a_packet_lands: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("taken packet produced no result");
`endif

endmodule

`default_nettype wire
